>>> rtl/channel_moving_average_unit_defines.svh
// ----------------------------------------------------------------------------
// Channel moving average unit - assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define CHANNEL_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// Channel moving average package
// Sizes, register codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

    localparam int MAX_WINDOW    = 64;
    localparam int SAMPLE_BITS   = 12;
    localparam int CHANNEL_COUNT = 8;
    localparam int CHANNEL_BITS  = 3;
    localparam int WLEN_BITS     = 7;
    localparam int FRAC_BITS     = 8;

    localparam int WIN_BITS      = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
    localparam int SUM_BITS      = SAMPLE_BITS + SLOT_BITS;
    localparam int QUOT_BITS     = SAMPLE_BITS + FRAC_BITS;
    localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
    localparam int HEAD_BITS     = DIVIDEND_BITS - QUOT_BITS;
    localparam int STEP_BITS     = $clog2(QUOT_BITS);
    localparam int AVG_BITS      = 20;
    localparam int USED_BITS     = 7;

    localparam int ADDR_BITS     = 3;
    localparam logic REG_FOLLOW_CHANNEL = 1'b0;
    localparam logic REG_WINDOW_LENGTH  = 1'b1;

    localparam logic [CHANNEL_BITS-1:0] FOLLOW_RESET = '0;
    localparam logic [WLEN_BITS-1:0]    WLEN_RESET   = WLEN_BITS'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_RESULT
    } cma_state_t;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [WIN_BITS-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                 valid;
        logic [AVG_BITS-1:0]  average;
        logic [USED_BITS-1:0] samples_used;
    } cma_result_t;

endpackage

`default_nettype wire

>>> rtl/channel_moving_average_unit.sv
// ----------------------------------------------------------------------------
// Channel moving average unit
// Sliding-window mean of the ADC samples of one selected channel, in raw
// codes with eight fraction bits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: start_req, channel_tag; tdata: sample_code
//  m_axis    out        tdata: average_q8, samples_used
//  APB       in/out     follow_channel at 0x0, window_length at 0x4
//
// A kept sample goes through a sum update, the iterations of the shared restoring
// divider, a state that sees it finish and one that hands the mean over to the
// output register; only then does the input reopen for the next sample.
// A sample of another channel is taken in the idle state and gives no result.
// Reset clears the sum, fill count and write slot but not the history memory.
// A stalled result waits in the output register, the next one in the sequencer.
//
`timescale 1ns / 1ps
`default_nettype none

module channel_moving_average_unit
    import cma_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,  // [11:0] sample_code
    input  wire logic [3:0]           s_axis_tuser,  // [0] start_req, [3:1] channel_tag

    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output      logic [31:0]          m_axis_tdata,  // [19:0] average_q8, [26:20] samples_used

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output      logic [31:0]          prdata,
    output      logic                 pready
);

    logic [CHANNEL_BITS-1:0] follow_reg, follow_next;
    logic [WLEN_BITS-1:0]    wlen_reg, wlen_next;
    logic                    cfg_write;
    logic                    window_clear;

    logic                    out_valid_reg, out_valid_next;
    logic [AVG_BITS-1:0]     out_avg_reg, out_avg_next;
    logic [USED_BITS-1:0]    out_used_reg, out_used_next;

    div_req_t                div_req;
    div_rsp_t                div_rsp;
    cma_result_t             result;
    logic                    result_taken;

    // ------------------------------------------------------------------
    // Configuration registers. Only address bit 2 selects the register;
    // writing the window length also empties the window.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        follow_next  = follow_reg;
        wlen_next    = wlen_reg;
        window_clear = 1'b0;
        if (cfg_write) begin
            case (paddr[2])
                REG_FOLLOW_CHANNEL: begin
                    follow_next = pwdata[CHANNEL_BITS-1:0];
                end
                REG_WINDOW_LENGTH: begin
                    wlen_next    = pwdata[WLEN_BITS-1:0];
                    window_clear = 1'b1;
                end
                default: begin
                    follow_next = follow_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FOLLOW_CHANNEL: prdata = 32'(follow_reg);
            REG_WINDOW_LENGTH:  prdata = 32'(wlen_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            follow_reg <= FOLLOW_RESET;
            wlen_reg   <= WLEN_RESET;
        end else begin
            follow_reg <= follow_next;
            wlen_reg   <= wlen_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and shared divider.
    // ------------------------------------------------------------------
    cma_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .start_req      (s_axis_tuser[0]),
        .channel_tag    (s_axis_tuser[3:1]),
        .sample_code    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .follow_channel (follow_reg),
        .window_length  (wlen_reg),
        .window_clear   (window_clear),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .result         (result),
        .result_taken   (result_taken)
    );

    cma_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Output register. A finished mean moves in whenever the register is
    // empty or its current transaction completes in the same cycle.
    // ------------------------------------------------------------------
    assign result_taken = result.valid && (!out_valid_reg || m_axis_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        out_used_next  = out_used_reg;
        if (result_taken) begin
            out_valid_next = 1'b1;
            out_avg_next   = result.average;
            out_used_next  = result.samples_used;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_avg_reg  <= out_avg_next;
        out_used_reg <= out_used_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(32 - AVG_BITS - USED_BITS){1'b0}}, out_used_reg, out_avg_reg};

endmodule

`default_nettype wire

>>> rtl/cma_history_ram.sv
// ----------------------------------------------------------------------------
// Sample history memory
// One write port and one registered read port over the window delay line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_history_ram
    import cma_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   wr_en,
    input  wire logic [SLOT_BITS-1:0]   wr_addr,
    input  wire logic [SAMPLE_BITS-1:0] wr_data,
    input  wire logic                   rd_en,
    input  wire logic [SLOT_BITS-1:0]   rd_addr,
    output      logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem_reg [MAX_WINDOW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/cma_divider.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces one quotient bit per cycle; the quotient is known to fit in
// QUOT_BITS, so the top dividend bits seed the partial remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_divider
    import cma_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output      div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [WIN_BITS-1:0]  rem_reg, rem_next;
    logic [QUOT_BITS-1:0] dq_reg, dq_next;
    logic [WIN_BITS-1:0]  divisor_reg, divisor_next;

    logic [WIN_BITS:0]    rem_shift;
    logic [WIN_BITS:0]    rem_sub;
    logic                 fits;

    assign rem_shift = {rem_reg, dq_reg[QUOT_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = WIN_BITS'(req.dividend[DIVIDEND_BITS-1 -: HEAD_BITS]);
            dq_next      = req.dividend[QUOT_BITS-1:0];
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_sub[WIN_BITS-1:0] : rem_shift[WIN_BITS-1:0];
            dq_next   = {dq_reg[QUOT_BITS-2:0], fits};
            step_next = step_reg + STEP_BITS'(1);
            if (step_reg == STEP_BITS'(QUOT_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

`default_nettype wire

>>> rtl/cma_ctrl.sv
// ----------------------------------------------------------------------------
// Window sequencer
// Filters samples by channel, updates the delay line and running sum, and
// hands the mean computation to the shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_ctrl
    import cma_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire logic                    start_req,
    input  wire logic [CHANNEL_BITS-1:0] channel_tag,
    input  wire logic [SAMPLE_BITS-1:0]  sample_code,
    input  wire logic [CHANNEL_BITS-1:0] follow_channel,
    input  wire logic [WLEN_BITS-1:0]    window_length,
    input  wire logic                    window_clear,
    output      div_req_t                div_req,
    input  wire div_rsp_t                div_rsp,
    output      cma_result_t             result,
    input  wire logic                    result_taken
);

    cma_state_t             state_reg, state_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [WIN_BITS-1:0]    fill_reg, fill_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [SLOT_BITS-1:0]   addr_reg, addr_next;
    logic [SAMPLE_BITS-1:0] code_reg, code_next;

    logic [WIN_BITS-1:0]    win;
    logic                   match;
    logic                   accept;
    logic                   clear;
    logic                   full;
    logic [SLOT_BITS-1:0]   slot_cur;
    logic [WIN_BITS-1:0]    slot_inc;
    logic [SUM_BITS-1:0]    sum_new;
    logic [WIN_BITS-1:0]    fill_new;
    logic [SAMPLE_BITS-1:0] old_code;
    logic                   rd_en;
    logic                   wr_en;

    // Zero acts as a window of one; larger values saturate at the memory depth.
    always_comb begin
        if (window_length == '0) begin
            win = WIN_BITS'(1);
        end else if (WIN_BITS'(window_length) > WIN_BITS'(MAX_WINDOW)) begin
            win = WIN_BITS'(MAX_WINDOW);
        end else begin
            win = WIN_BITS'(window_length);
        end
    end

    assign match    = (channel_tag == follow_channel)
                   && (int'(channel_tag) < CHANNEL_COUNT);
    assign accept   = in_valid && in_ready;
    assign clear    = window_clear || (accept && start_req);
    assign full     = (fill_reg >= win);
    assign slot_cur = (clear || (WIN_BITS'(slot_reg) >= win)) ? '0 : slot_reg;
    assign slot_inc = WIN_BITS'(addr_reg) + WIN_BITS'(1);
    assign sum_new  = full ? (sum_reg - SUM_BITS'(old_code) + SUM_BITS'(code_reg))
                           : (sum_reg + SUM_BITS'(code_reg));
    assign fill_new = full ? win : (fill_reg + WIN_BITS'(1));

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        slot_next  = slot_reg;
        addr_next  = addr_reg;
        code_next  = code_reg;
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        div_req    = '{start: 1'b0, dividend: {sum_new, {FRAC_BITS{1'b0}}},
                       divisor: fill_new};
        result     = '{valid: 1'b0, average: AVG_BITS'(div_rsp.quotient),
                       samples_used: USED_BITS'(fill_reg)};
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (clear) begin
                    sum_next  = '0;
                    fill_next = '0;
                    slot_next = '0;
                end
                if (accept && match) begin
                    rd_en      = 1'b1;
                    addr_next  = slot_cur;
                    code_next  = sample_code;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                wr_en         = 1'b1;
                div_req.start = 1'b1;
                sum_next      = sum_new;
                fill_next     = fill_new;
                slot_next     = (slot_inc >= win) ? '0 : slot_inc[SLOT_BITS-1:0];
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                result.valid = 1'b1;
                if (result_taken) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            fill_reg  <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        code_reg <= code_next;
    end

    cma_history_ram u_history (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (code_reg),
        .rd_en   (rd_en),
        .rd_addr (slot_cur),
        .rd_data (old_code)
    );

endmodule

`default_nettype wire

>>> rtl/cma_checker.sv
// ----------------------------------------------------------------------------
// Channel moving average port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "channel_moving_average_unit_defines.svh"

module cma_checker
    import cma_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A stalled result keeps its data.
    `CMA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // The sample count of a mean lies between one and the memory depth.
    `CMA_ASSERT_SAME(a_used_range, aclk, aresetn, m_axis_tvalid, (m_axis_tdata[26:20] != 7'd0) && (m_axis_tdata[26:20] <= 7'(MAX_WINDOW)), "samples_used out of range")

    // The input only closes right after a transaction.
    `CMA_ASSERT_SAME(a_busy_after_accept, aclk, aresetn, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tready), "input closed without a transaction")

    // A new result only appears while the sequencer is working.
    `CMA_ASSERT_SAME(a_result_from_work, aclk, aresetn, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared while idle")

endmodule

bind channel_moving_average_unit cma_checker u_cma_checker (.*);

`default_nettype wire

>>> tb/sv/channel_moving_average_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel moving average unit - self-checking testbench
// Streams tagged ADC samples into the unit and checks every average it
// returns against a predictor that keeps its own window, sum and register
// copies. The run covers a directed sequence at the reset settings and then
// random traffic under several channel and window length settings, with
// random idle cycles on both streams and long output stalls.
// ----------------------------------------------------------------------------

module channel_moving_average_unit_test;

    import cma_pkg::*;

    // Register byte addresses, built from the register codes of the package.
    localparam logic [ADDR_BITS-1:0] FOLLOW_ADDR = {REG_FOLLOW_CHANNEL, 2'b00};
    localparam logic [ADDR_BITS-1:0] LENGTH_ADDR = {REG_WINDOW_LENGTH, 2'b00};

    // A kept sample only reaches the output register after the divider, so a short
    // settle time after the last expected average covers any work in flight.
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 188;

    typedef struct packed {
        logic [AVG_BITS-1:0]  average;
        logic [USED_BITS-1:0] used;
    } mean_t;

    // Predicts the average for each accepted sample of the followed channel and
    // holds the averages that are still on their way out of the unit.
    class mean_tracker;
        logic [CHANNEL_BITS-1:0] channel;
        logic [WLEN_BITS-1:0]    length;
        logic [SAMPLE_BITS-1:0]  taps [MAX_WINDOW];
        logic [SUM_BITS-1:0]     window_total;
        int                      fill;
        int                      slot;
        mean_t                   pending_means [$];
        int                      mismatches;

        function new();
            channel    = FOLLOW_RESET;
            length     = WLEN_RESET;
            mismatches = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (taps[i]) taps[i] = '0;
            window_total = '0;
            fill         = 0;
            slot         = 0;
        endfunction

        // A new window length always starts an empty window.
        function void set_length(logic [WLEN_BITS-1:0] value);
            length = value;
            clear_window();
        endfunction

        function void note_sample(logic start, logic [CHANNEL_BITS-1:0] tag,
                                  logic [SAMPLE_BITS-1:0] code);
            int                             span;
            logic [SUM_BITS+FRAC_BITS-1:0]  scaled;
            mean_t                          m;
            span = (length == 0) ? 1 : ((length > MAX_WINDOW) ? MAX_WINDOW : int'(length));
            // The start flag clears the window even for a foreign sample.
            if (start) clear_window();
            if (tag != channel) return;
            if (slot >= span) slot = 0;
            if (fill >= span) begin
                // Full window: the oldest sample sits in the slot about to be reused.
                window_total = window_total - taps[slot];
                fill = span;
            end else begin
                fill++;
            end
            taps[slot]   = code;
            window_total = window_total + code;
            slot++;
            if (slot >= span) slot = 0;
            scaled    = window_total;
            scaled    = scaled << FRAC_BITS;
            m.average = AVG_BITS'(scaled / fill);
            m.used    = USED_BITS'(fill);
            pending_means.push_back(m);
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_mean(logic [31:0] data);
            mean_t want;
            if (pending_means.size() == 0) begin
                report($sformatf("unexpected average %0d over %0d samples",
                                 data[AVG_BITS-1:0], data[AVG_BITS +: USED_BITS]));
                return;
            end
            want = pending_means.pop_front();
            if (data[AVG_BITS-1:0] !== want.average)
                report($sformatf("average_q8 is %0d, predicted %0d",
                                 data[AVG_BITS-1:0], want.average));
            if (data[AVG_BITS +: USED_BITS] !== want.used)
                report($sformatf("samples_used is %0d, predicted %0d",
                                 data[AVG_BITS +: USED_BITS], want.used));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [11:0] sample_code
    logic [3:0]  s_axis_tuser;   // [0] start_req, [3:1] channel_tag
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [19:0] average_q8, [26:20] samples_used
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    mean_tracker book = new();

    // Each side toggles now and then into a calm stretch with no idle cycles.
    bit source_calm = 1'b0;
    bit sink_calm   = 1'b0;

    channel_moving_average_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Idle cycles before the next transaction on one side are drawn at random,
    // or there are none at all during a calm stretch.
    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    // Offers one sample and returns at the edge where it is accepted. The
    // predictor sees the sample at that same edge.
    task automatic send_sample(input logic start, input logic [CHANNEL_BITS-1:0] tag,
                               input logic [SAMPLE_BITS-1:0] code);
        int gap;
        gap = pick_gap(source_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16 - SAMPLE_BITS){1'b0}}, code};
        s_axis_tuser  <= {tag, start};
        do @(posedge aclk); while (!s_axis_tready);
        book.note_sample(start, tag, code);
    endtask

    // Random traffic: mostly samples of the followed channel, so the window
    // fills and wraps, with foreign samples and rare restarts mixed in. Codes
    // lean toward the two ends of the range.
    task automatic send_random(input int count);
        logic                    start;
        logic [CHANNEL_BITS-1:0] tag;
        logic [SAMPLE_BITS-1:0]  code;
        repeat (count) begin
            start = ($urandom_range(0, 95) == 0);
            if ($urandom_range(0, 3) != 0)
                tag = book.channel;
            else
                tag = CHANNEL_BITS'($urandom_range(0, CHANNEL_COUNT - 1));
            case ($urandom_range(0, 7))
                0: code = '0;
                1: code = '1;
                default: code = SAMPLE_BITS'($urandom);
            endcase
            send_sample(start, tag, code);
        end
    endtask

    // Stops offering samples, waits for every predicted average and then lets
    // the unit settle, so that a register write finds it idle.
    task automatic drain_means();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (book.pending_means.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes a register with a setup and an access cycle, then reads it back
    // in a second transfer that follows directly.
    task automatic set_register(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == FOLLOW_ADDR) begin
            book.channel = value[CHANNEL_BITS-1:0];
            readback = 32'(book.channel);
        end else begin
            book.set_length(value[WLEN_BITS-1:0]);
            readback = 32'(book.length);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== readback)
            book.report($sformatf("register at 0x%0h reads 0x%0h, written 0x%0h",
                                  addr, prdata, readback));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side. The ready line drops for a random number of cycles after
    // each transaction. Twice it stays low for a long stretch while the source
    // keeps offering samples, so the output register and the sequencer fill
    // up and the unit has to hold off its input.
    initial begin : result_sink
        int stall;
        int results_seen;
        stall        = 0;
        results_seen = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                book.check_mean(m_axis_tdata);
                results_seen++;
                if (results_seen == 150 || results_seen == 700)
                    stall = LONG_HOLD;
                else
                    stall = pick_gap(sink_calm);
            end else if (stall > 0) begin
                stall--;
            end
            m_axis_tready <= (stall == 0);
        end
    end

    // Main sequence: reset, a directed pass at the reset settings, then random
    // phases under changing settings. The first phase uses the widest window
    // with the highest channel, the second changes only the channel so the
    // filled window carries over, the third uses a window of one.
    initial begin : stimulus
        int follow_plan [6];
        int length_plan [6];
        int follow_next;
        int length_next;
        follow_plan   = '{7, 3, 0, 5, 2, 0};
        length_plan   = '{64, 0, 1, 2, 33, 0};
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at the reset settings: channel 0, window of 8.
        send_sample(1'b0, 3'd0, 12'd0);
        send_sample(1'b0, 3'd0, 12'd4095);
        send_sample(1'b0, 3'd5, 12'd1234);       // foreign sample, no average
        send_sample(1'b1, 3'd3, 12'd77);         // restart carried by a foreign sample
        send_sample(1'b0, 3'd0, 12'd100);        // fresh window of one
        // Full-scale codes past the window size give the largest average and
        // make the window drop its oldest entries.
        repeat (9) send_sample(1'b0, 3'd0, 12'd4095);
        send_sample(1'b1, 3'd0, 12'd4095);       // restart on a kept sample
        send_sample(1'b0, 3'd7, 12'd4095);       // highest foreign channel
        send_sample(1'b0, 3'd0, 12'd1);
        send_sample(1'b0, 3'd0, 12'd2048);
        send_sample(1'b0, 3'd0, 12'd4094);
        drain_means();

        for (int p = 0; p < 6; p++) begin
            follow_next = follow_plan[p];
            length_next = length_plan[p];
            if (p == 5) begin
                follow_next = $urandom_range(0, CHANNEL_COUNT - 1);
                length_next = $urandom_range(1, MAX_WINDOW);
            end
            set_register(FOLLOW_ADDR, 32'(follow_next));
            // A zero in the plan keeps the current window and its contents.
            if (length_next != 0)
                set_register(LENGTH_ADDR, 32'(length_next));
            send_random(PHASE_ITEMS);
            drain_means();
        end

        if (book.pending_means.size() != 0)
            book.report($sformatf("%0d predicted averages never arrived",
                                  book.pending_means.size()));
        if (book.mismatches == 0) begin
            $display("** channel_moving_average_unit: PASSED **");
        end else begin
            $display("** channel_moving_average_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $display("** channel_moving_average_unit: FAILED **");
        $finish;
    end

endmodule

>>> channel_moving_average_unit.f
+incdir+rtl
rtl/cma_pkg.sv
rtl/cma_history_ram.sv
rtl/cma_divider.sv
rtl/cma_ctrl.sv
rtl/channel_moving_average_unit.sv
rtl/cma_checker.sv
tb/sv/channel_moving_average_unit_test.sv
